/* hdl/mfap_pkg.sv */
// ----------------------------------------------------------------------------
// mfap_pkg
// Shared types and codes for the max-flow augmenting path core.
// ----------------------------------------------------------------------------
package mfap_pkg;

   localparam int NODE_FIELD_W = 6;
   localparam int CAP_FIELD_W  = 16;
   localparam int CMD_W        = 2;
   localparam int FLOW_W       = 22;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_SOLVE = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SINK   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT  = 2'd2;

   typedef enum logic [1:0] {
      ALU_MIN    = 2'd0,
      ALU_SUB    = 2'd1,
      ALU_SATADD = 2'd2
   } alu_op_type;

   typedef struct packed {
      logic [CMD_W-1:0]        command;
      logic [NODE_FIELD_W-1:0] from_node;
      logic [NODE_FIELD_W-1:0] to_node;
      logic [CAP_FIELD_W-1:0]  capacity;
   } req_word_type;

   typedef struct packed {
      logic [NODE_FIELD_W-1:0] source_node;
      logic [NODE_FIELD_W-1:0] sink_node;
      logic [CSR_DATA_W-1:0]   node_count;
   } cfg_type;

endpackage

/* hdl/mfap_req_if.sv */
// ----------------------------------------------------------------------------
// mfap_req_if
// Command channel: valid/ready plus one command word.
// ----------------------------------------------------------------------------
interface mfap_req_if;
   logic                                valid;
   logic                                ready;
   logic [mfap_pkg::CMD_W-1:0]          command;
   logic [mfap_pkg::NODE_FIELD_W-1:0]   from_node;
   logic [mfap_pkg::NODE_FIELD_W-1:0]   to_node;
   logic [mfap_pkg::CAP_FIELD_W-1:0]    capacity;

   modport source (output valid, command, from_node, to_node, capacity, input ready);
   modport sink   (input valid, command, from_node, to_node, capacity, output ready);
endinterface

/* hdl/mfap_rsp_if.sv */
// ----------------------------------------------------------------------------
// mfap_rsp_if
// Result channel: valid/ready plus the flow total.
// ----------------------------------------------------------------------------
interface mfap_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mfap_pkg::FLOW_W-1:0]   total_flow;

   modport source (output valid, total_flow, input ready);
   modport sink   (input valid, total_flow, output ready);
endinterface

/* hdl/max_flow_augmenting_path_core.sv */
// Clear writes every matrix entry, one matrix entry a cycle; an add edge word writes one entry.
// Solve: S_INIT starts a search, S_DEQ and S_DEQW dequeue, S_SRD reads, S_SCHK checks a node;
//   an empty queue goes to S_EMIT; path edges run S_A0-S_A4, S_ACHK. One matrix port sets pace.
// Throughput: edges one word a cycle; clear and solve hold off requests until finished.
// Reset: synchronous, active high; after reset a clearing pass zeroes the matrix before the
//   first request word is taken; config registers take writes.
// ----------------------------------------------------------------------------
// max_flow_augmenting_path_core
// Edmonds-Karp maximum flow over a residual capacity matrix held in RAM.
// ----------------------------------------------------------------------------
module max_flow_augmenting_path_core #(
   parameter int MAX_NODES = 64,
   parameter int CAP_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   mfap_req_if.sink                             req,
   mfap_rsp_if.source                           rsp,
   input  logic                                 csr_we,
   input  logic [mfap_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mfap_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   // config registers
   logic [mfap_pkg::NODE_FIELD_W-1:0] source_ff, source_in;
   logic [mfap_pkg::NODE_FIELD_W-1:0] sink_ff, sink_in;
   logic [mfap_pkg::CSR_DATA_W-1:0]   count_ff, count_in;
   mfap_pkg::cfg_type                 cfg;
   mfap_pkg::req_word_type            req_word;

   always_comb begin
      source_in = source_ff;
      sink_in   = sink_ff;
      count_in  = count_ff;
      if (csr_we) begin
         unique case (csr_index)
            mfap_pkg::CSR_SOURCE: source_in = csr_wdata[mfap_pkg::NODE_FIELD_W-1:0];
            mfap_pkg::CSR_SINK:   sink_in   = csr_wdata[mfap_pkg::NODE_FIELD_W-1:0];
            mfap_pkg::CSR_COUNT:  count_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_ff <= '0;
         sink_ff   <= 6'd63;
         count_ff  <= 7'd64;
      end else begin
         source_ff <= source_in;
         sink_ff   <= sink_in;
         count_ff  <= count_in;
      end
   end

   assign cfg.source_node = source_ff;
   assign cfg.sink_node   = sink_ff;
   assign cfg.node_count  = count_ff;

   assign req_word.command   = req.command;
   assign req_word.from_node = req.from_node;
   assign req_word.to_node   = req.to_node;
   assign req_word.capacity  = req.capacity;

   // the engine holds the result word, so a finished total waits there while idle
   mfap_engine #(.MAX_NODES(MAX_NODES), .CAP_BITS(CAP_BITS)) u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_ready  (req.ready),
      .req_word   (req_word),
      .cfg        (cfg),
      .rsp_valid  (rsp.valid),
      .rsp_ready  (rsp.ready),
      .total_flow (rsp.total_flow)
   );

   // a solve or clear word holds off the next request
   a_solve_busy: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.command == mfap_pkg::CMD_SOLVE) |=> !req.ready)
      else $error("request taken straight after solve");

   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.command == mfap_pkg::CMD_CLEAR) |=> !req.ready)
      else $error("request taken straight after clear");

   // edge loads stream one word a cycle
   a_edge_stream: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.command == mfap_pkg::CMD_ADD) |=> req.ready)
      else $error("edge load stalled the request channel");
endmodule

/* hdl/mfap_alu.sv */
// ----------------------------------------------------------------------------
// mfap_alu
// Shared residual arithmetic: minimum, subtract, saturating add.
// ----------------------------------------------------------------------------
module mfap_alu #(
   parameter int W = 17
) (
   input  mfap_pkg::alu_op_type op,
   input  logic [W-1:0]         a,
   input  logic [W-1:0]         b,
   output logic [W-1:0]         y
);
   logic [W:0] sum;

   assign sum = {1'b0, a} + {1'b0, b};

   always_comb begin
      unique case (op)
         mfap_pkg::ALU_MIN:    y = (a < b) ? a : b;
         mfap_pkg::ALU_SUB:    y = a - b;
         mfap_pkg::ALU_SATADD: y = sum[W] ? {W{1'b1}} : sum[W-1:0];
         default:              y = a;
      endcase
   end
endmodule

/* hdl/mfap_matrix.sv */
// ----------------------------------------------------------------------------
// mfap_matrix
// Residual matrix store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mfap_matrix #(
   parameter int AW = 12,
   parameter int DW = 17
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);
   logic [DW-1:0] mem [1<<AW];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* hdl/mfap_engine.sv */
// ----------------------------------------------------------------------------
// mfap_engine
// Sequencer: matrix clear, edge load, BFS search and path augmentation.
// ----------------------------------------------------------------------------
module mfap_engine #(
   parameter int MAX_NODES = 64,
   parameter int CAP_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  mfap_pkg::req_word_type        req_word,
   input  mfap_pkg::cfg_type             cfg,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mfap_pkg::FLOW_W-1:0]   total_flow
);
   localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int QW = NW + 1;
   localparam int AW = 2 * NW;
   localparam int RW = CAP_BITS + 1;
   localparam int FW = mfap_pkg::FLOW_W;

   typedef enum logic [13:0] {
      S_CLR  = 14'b00000000000001,
      S_IDLE = 14'b00000000000010,
      S_INIT = 14'b00000000000100,
      S_DEQ  = 14'b00000000001000,
      S_DEQW = 14'b00000000010000,
      S_SRD  = 14'b00000000100000,
      S_SCHK = 14'b00000001000000,
      S_A0   = 14'b00000010000000,
      S_A1   = 14'b00000100000000,
      S_A2   = 14'b00001000000000,
      S_A3   = 14'b00010000000000,
      S_A4   = 14'b00100000000000,
      S_ACHK = 14'b01000000000000,
      S_EMIT = 14'b10000000000000
   } state_type;

   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [QW-1:0]     head_ff, head_in, tail_ff, tail_in, guard_ff, guard_in;
   logic [NW-1:0]     u_ff, u_in, v_ff, v_in, cur_ff, cur_in;
   logic [RW-1:0]     b_ff, b_in, f_ff, f_in;
   logic [FW-1:0]     flow_ff, flow_in, total_flow_ff, total_flow_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [MAX_NODES-1:0] visited_ff, visited_in;

   // search queue and parent table
   logic [NW-1:0]     q_node_mem [MAX_NODES];
   logic [RW-1:0]     q_bot_mem  [MAX_NODES];
   logic [NW-1:0]     par_mem    [MAX_NODES];
   logic [NW-1:0]     q_node_rd_ff, par_rd_ff;
   logic [RW-1:0]     q_bot_rd_ff;
   logic              q_we, par_we;
   logic [NW-1:0]     q_waddr, q_raddr, par_waddr, par_raddr, q_wnode, par_wdata;
   logic [RW-1:0]     q_wbot;

   logic              mem_we;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [RW-1:0]     mem_wdata, mem_rdata;

   mfap_pkg::alu_op_type alu_op;
   logic [RW-1:0]     alu_a, alu_b, alu_y;

   logic [QW-1:0]     n_eff;
   logic [NW-1:0]     src, dst;
   logic              ends_bad, add_ok;
   logic [FW:0]       flow_sum;
   logic [RW-1:0]     cap_val;

   mfap_matrix #(.AW(AW), .DW(RW)) u_matrix (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   mfap_alu #(.W(RW)) u_alu (
      .op (alu_op),
      .a  (alu_a),
      .b  (alu_b),
      .y  (alu_y)
   );

   assign n_eff = (32'(cfg.node_count) < MAX_NODES) ? QW'(cfg.node_count) : QW'(MAX_NODES);
   assign src   = NW'(cfg.source_node);
   assign dst   = NW'(cfg.sink_node);
   assign ends_bad = (32'(cfg.source_node) >= 32'(n_eff)) ||
                     (32'(cfg.sink_node) >= 32'(n_eff)) ||
                     (cfg.source_node == cfg.sink_node);
   assign add_ok = (32'(req_word.from_node) < MAX_NODES) &&
                   (32'(req_word.to_node) < MAX_NODES);
   assign cap_val = RW'(req_word.capacity[mfap_pkg::CAP_FIELD_W-1:0] &
                        mfap_pkg::CAP_FIELD_W'((64'd1 << CAP_BITS) - 64'd1));
   assign flow_sum = {1'b0, flow_ff} + (FW+1)'(alu_y);

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign total_flow = total_flow_ff;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      guard_in      = guard_ff;
      u_in          = u_ff;
      v_in          = v_ff;
      cur_in        = cur_ff;
      b_in          = b_ff;
      f_in          = f_ff;
      flow_in       = flow_ff;
      total_flow_in = total_flow_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      visited_in    = visited_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      mem_raddr     = '0;
      q_we          = 1'b0;
      q_waddr       = '0;
      q_wnode       = '0;
      q_wbot        = '0;
      q_raddr       = '0;
      par_we        = 1'b0;
      par_waddr     = '0;
      par_wdata     = '0;
      par_raddr     = '0;
      alu_op        = mfap_pkg::ALU_MIN;
      alu_a         = mem_rdata;
      alu_b         = b_ff;

      unique case (state_ff)
         S_CLR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == {AW{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_word.command)
                  mfap_pkg::CMD_CLEAR: begin
                     clr_in   = '0;
                     state_in = S_CLR;
                  end
                  mfap_pkg::CMD_ADD: begin
                     mem_we    = add_ok;
                     mem_waddr = {NW'(req_word.from_node), NW'(req_word.to_node)};
                     mem_wdata = cap_val;
                  end
                  mfap_pkg::CMD_SOLVE: begin
                     flow_in  = '0;
                     state_in = ends_bad ? S_EMIT : S_INIT;
                  end
                  default: ;
               endcase
            end
         end
         S_INIT: begin
            visited_in      = '0;
            visited_in[src] = 1'b1;
            q_we            = 1'b1;
            q_waddr         = '0;
            q_wnode         = src;
            q_wbot          = {RW{1'b1}};
            head_in         = '0;
            tail_in         = QW'(1);
            state_in        = S_DEQ;
         end
         S_DEQ: begin
            if (head_ff == tail_ff) begin
               state_in = S_EMIT;
            end else begin
               q_raddr  = head_ff[NW-1:0];
               head_in  = head_ff + 1'b1;
               state_in = S_DEQW;
            end
         end
         S_DEQW: begin
            u_in     = q_node_rd_ff;
            b_in     = q_bot_rd_ff;
            v_in     = '0;
            state_in = S_SRD;
         end
         S_SRD: begin
            mem_raddr = {u_ff, v_ff};
            state_in  = S_SCHK;
         end
         S_SCHK: begin
            // alu gives min(residual, bottleneck of u)
            if (!visited_ff[v_ff] && (mem_rdata != '0)) begin
               visited_in[v_ff] = 1'b1;
               par_we    = 1'b1;
               par_waddr = v_ff;
               par_wdata = u_ff;
            end
            if (!visited_ff[v_ff] && (mem_rdata != '0) && (v_ff == dst)) begin
               f_in     = alu_y;
               flow_in  = flow_sum[FW] ? {FW{1'b1}} : flow_sum[FW-1:0];
               cur_in   = dst;
               guard_in = '0;
               state_in = S_A0;
            end else begin
               if (!visited_ff[v_ff] && (mem_rdata != '0) && (32'(tail_ff) < MAX_NODES)) begin
                  q_we    = 1'b1;
                  q_waddr = tail_ff[NW-1:0];
                  q_wnode = v_ff;
                  q_wbot  = alu_y;
                  tail_in = tail_ff + 1'b1;
               end
               if ({1'b0, v_ff} == n_eff - 1'b1) begin
                  state_in = S_DEQ;
               end else begin
                  v_in     = v_ff + 1'b1;
                  state_in = S_SRD;
               end
            end
         end
         S_A0: begin
            par_raddr = cur_ff;
            state_in  = S_A1;
         end
         S_A1: begin
            u_in     = par_rd_ff;
            state_in = S_A2;
         end
         S_A2: begin
            mem_raddr = {u_ff, cur_ff};
            state_in  = S_A3;
         end
         S_A3: begin
            // forward residual down, then fetch the reverse one
            alu_op    = mfap_pkg::ALU_SUB;
            alu_b     = f_ff;
            mem_we    = 1'b1;
            mem_waddr = {u_ff, cur_ff};
            mem_wdata = alu_y;
            mem_raddr = {cur_ff, u_ff};
            state_in  = S_A4;
         end
         S_A4: begin
            alu_op    = mfap_pkg::ALU_SATADD;
            alu_b     = f_ff;
            mem_we    = 1'b1;
            mem_waddr = {cur_ff, u_ff};
            mem_wdata = alu_y;
            cur_in    = u_ff;
            guard_in  = guard_ff + 1'b1;
            state_in  = S_ACHK;
         end
         S_ACHK: begin
            if ((cur_ff == src) || (guard_ff == QW'(MAX_NODES))) begin
               state_in = S_INIT;
            end else begin
               state_in = S_A0;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               total_flow_in = flow_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         visited_ff   <= '0;
         flow_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         guard_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         visited_ff   <= visited_in;
         flow_ff      <= flow_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         guard_ff     <= guard_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff          <= u_in;
      v_ff          <= v_in;
      cur_ff        <= cur_in;
      b_ff          <= b_in;
      f_ff          <= f_in;
      total_flow_ff <= total_flow_in;
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         q_node_mem[q_waddr] <= q_wnode;
         q_bot_mem[q_waddr]  <= q_wbot;
      end
      if (par_we) begin
         par_mem[par_waddr] <= par_wdata;
      end
      q_node_rd_ff <= q_node_mem[q_raddr];
      q_bot_rd_ff  <= q_bot_mem[q_raddr];
      par_rd_ff    <= par_mem[par_raddr];
   end
endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for max_flow_augmenting_path_core: drives command words
// with random gaps, holds its own residual matrix and breadth-first search to
// predict each solve total, and checks every result word against it.
// ----------------------------------------------------------------------------
module tb;

   localparam int NODES       = 64;
   localparam int IDLE_LIMIT  = 8000000;   // a dense solve at 64 nodes is slow
   localparam int CLEAR_WAIT  = 4200;      // one matrix entry per cycle, plus margin
   localparam int RANDOM_WORDS = 1700;
   localparam logic [16:0] RES_FULL  = 17'h1FFFF;
   localparam logic [21:0] FLOW_FULL = 22'h3FFFFF;

   logic clock;
   logic reset;
   logic csr_we;
   logic [mfap_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [mfap_pkg::CSR_DATA_W-1:0] csr_wdata;

   mfap_req_if req ();
   mfap_rsp_if rsp ();

   max_flow_augmenting_path_core dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 4 ns clock
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Predictor state: shadow of the block's matrix and registers
   logic [16:0] residual [NODES][NODES];
   logic [5:0]  cfg_source;
   logic [5:0]  cfg_sink;
   logic [6:0]  cfg_count;

   logic [21:0] flow_expected [$];
   int          fail_count;
   int          words_sent;
   int          idle_cycles;
   bit          gaps_on;
   bit          clear_pending;   // a clear may still be sweeping the matrix

   // Edmonds-Karp on the shadow matrix; updates residuals, returns the total
   function automatic logic [21:0] predict_total_flow();
      int          n, src, dst, head, tail, u, v, guard;
      int          queue_node [NODES];
      logic [16:0] queue_neck [NODES];
      int          parent [NODES];
      bit          seen [NODES];
      logic [16:0] neck, r, nb, f;
      logic [17:0] raised;
      logic [22:0] total;
      n     = (int'(cfg_count) < NODES) ? int'(cfg_count) : NODES;
      src   = int'(cfg_source);
      dst   = int'(cfg_sink);
      total = '0;
      if (src >= n || dst >= n || src == dst) return '0;
      forever begin
         f = '0;
         foreach (seen[i]) seen[i] = 1'b0;
         seen[src]     = 1'b1;
         queue_node[0] = src;
         queue_neck[0] = RES_FULL;
         head = 0;
         tail = 1;
         while (head < tail && f == '0) begin
            u    = queue_node[head];
            neck = queue_neck[head];
            head++;
            for (v = 0; v < n; v++) begin
               r = residual[u][v];
               if (seen[v] || r == '0) continue;
               seen[v]   = 1'b1;
               parent[v] = u;
               nb = (r < neck) ? r : neck;
               if (v == dst) begin
                  f = nb;
                  break;
               end
               if (tail < NODES) begin
                  queue_node[tail] = v;
                  queue_neck[tail] = nb;
                  tail++;
               end
            end
         end
         if (f == '0) break;
         total = (total + f > FLOW_FULL) ? {1'b0, FLOW_FULL} : total + f;
         // push the bottleneck back along the path
         v     = dst;
         guard = 0;
         while (v != src && guard < NODES) begin
            u = parent[v];
            raised = residual[v][u] + f;
            residual[u][v] = residual[u][v] - f;
            residual[v][u] = (raised > RES_FULL) ? RES_FULL : raised[16:0];
            v = u;
            guard++;
         end
      end
      return total[21:0];
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (!gaps_on || roll < 60) return 0;
      if (roll < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 5);
   endfunction

   // Send one command word and update the predictor when it is taken
   task automatic send_word(mfap_pkg::cmd_type cmd, logic [5:0] a, logic [5:0] b,
                            logic [15:0] cap);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.command   <= cmd;
      req.from_node <= a;
      req.to_node   <= b;
      req.capacity  <= cap;
      do @(posedge clock); while (!req.ready);
      case (cmd)
         mfap_pkg::CMD_CLEAR: begin
            foreach (residual[i, j]) residual[i][j] = '0;
            clear_pending = 1'b1;
         end
         mfap_pkg::CMD_ADD:   residual[a][b] = {1'b0, cap};
         mfap_pkg::CMD_SOLVE: flow_expected.insert(flow_expected.size(), predict_total_flow());
         default: ;
      endcase
      if (cmd != mfap_pkg::CMD_NONE) words_sent++;
   endtask

   // Sender holds off until every expected total has come back
   task automatic wait_idle();
      req.valid <= 1'b0;
      while (flow_expected.size() != 0) @(posedge clock);
      repeat (clear_pending ? CLEAR_WAIT : 8) @(posedge clock);
      clear_pending = 1'b0;
   endtask

   // csr_we stays high between back-to-back writes; set_config drops it
   task automatic write_csr(logic [mfap_pkg::CSR_IDX_W-1:0] idx,
                            logic [mfap_pkg::CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         mfap_pkg::CSR_SOURCE: cfg_source = value[5:0];
         mfap_pkg::CSR_SINK:   cfg_sink   = value[5:0];
         mfap_pkg::CSR_COUNT:  cfg_count  = value;
         default: ;
      endcase
   endtask

   task automatic set_config(logic [5:0] src, logic [5:0] dst, logic [6:0] n);
      wait_idle();
      write_csr(mfap_pkg::CSR_SOURCE, {1'b0, src});
      write_csr(mfap_pkg::CSR_SINK, {1'b0, dst});
      write_csr(mfap_pkg::CSR_COUNT, n);
      csr_we <= 1'b0;
   endtask

   // Reset defaults, the simplest graphs and every command
   task automatic test_basic_commands();
      send_word(mfap_pkg::CMD_SOLVE, 6'd0, 6'd0, 16'd0);          // empty matrix
      send_word(mfap_pkg::CMD_ADD, 6'd0, 6'd63, 16'hFFFF);
      send_word(mfap_pkg::CMD_NONE, 6'd63, 6'd0, 16'h5A5A);       // unused command, ignored
      send_word(mfap_pkg::CMD_SOLVE, 6'd0, 6'd0, 16'd0);
      send_word(mfap_pkg::CMD_SOLVE, 6'd0, 6'd0, 16'd0);          // residual already drained
      send_word(mfap_pkg::CMD_ADD, 6'd0, 6'd1, 16'd7);
      send_word(mfap_pkg::CMD_ADD, 6'd1, 6'd63, 16'd3);
      send_word(mfap_pkg::CMD_ADD, 6'd0, 6'd2, 16'd0);            // zero capacity edge
      send_word(mfap_pkg::CMD_ADD, 6'd1, 6'd63, 16'd5);           // overwrite
      send_word(mfap_pkg::CMD_SOLVE, 6'd0, 6'd0, 16'd0);
      send_word(mfap_pkg::CMD_CLEAR, 6'd0, 6'd0, 16'd0);
      send_word(mfap_pkg::CMD_ADD, 6'd0, 6'd63, 16'd1);
      send_word(mfap_pkg::CMD_SOLVE, 6'd0, 6'd0, 16'd0);
   endtask

   // Source equal to sink, endpoints beyond node_count, smallest graph, node counts out of range
   task automatic test_endpoint_cases();
      set_config(6'd4, 6'd4, 7'd64);
      send_word(mfap_pkg::CMD_ADD, 6'd4, 6'd5, 16'd9);
      send_word(mfap_pkg::CMD_SOLVE, 6'd0, 6'd0, 16'd0);
      set_config(6'd10, 6'd1, 7'd5);
      send_word(mfap_pkg::CMD_ADD, 6'd10, 6'd1, 16'd9);
      send_word(mfap_pkg::CMD_SOLVE, 6'd0, 6'd0, 16'd0);
      set_config(6'd1, 6'd0, 7'd2);
      send_word(mfap_pkg::CMD_ADD, 6'd1, 6'd0, 16'd11);
      send_word(mfap_pkg::CMD_SOLVE, 6'd0, 6'd0, 16'd0);
      set_config(6'd1, 6'd0, 7'd1);                     // below the legal range
      send_word(mfap_pkg::CMD_SOLVE, 6'd0, 6'd0, 16'd0);
      set_config(6'd0, 6'd63, 7'd127);                  // above MAX_NODES
      send_word(mfap_pkg::CMD_SOLVE, 6'd0, 6'd0, 16'd0);
   endtask

   // Full-capacity fan through every node, repeated so reverse residuals
   // saturate, then reversed so the total saturates
   task automatic fan_round();
      for (int k = 1; k < 63; k++) begin
         send_word(mfap_pkg::CMD_ADD, 6'd0, k[5:0], 16'hFFFF);
         send_word(mfap_pkg::CMD_ADD, k[5:0], 6'd63, 16'hFFFF);
      end
      send_word(mfap_pkg::CMD_SOLVE, 6'd0, 6'd0, 16'd0);
   endtask

   task automatic test_saturation();
      set_config(6'd0, 6'd63, 7'd64);
      send_word(mfap_pkg::CMD_CLEAR, 6'd0, 6'd0, 16'd0);
      send_word(mfap_pkg::CMD_ADD, 6'd0, 6'd63, 16'hFFFF);
      fan_round();
      fan_round();
      set_config(6'd63, 6'd0, 7'd64);
      send_word(mfap_pkg::CMD_SOLVE, 6'd0, 6'd0, 16'd0);
      set_config(6'd0, 6'd63, 7'd64);
      fan_round();
   endtask

   function automatic logic [15:0] random_capacity();
      int roll;
      roll = $urandom_range(99);
      if (roll < 50) return 16'($urandom_range(20, 1));
      if (roll < 80) return 16'($urandom_range(16'hFFFF));
      if (roll < 90) return 16'd0;
      return 16'hFFFF;
   endfunction

   // Random graphs: mostly small node counts, a few full-size sparse ones
   task automatic test_random_graphs();
      int          roll, n, edges;
      logic [5:0]  src, dst, a, b;
      logic [6:0]  count;
      while (words_sent < RANDOM_WORDS) begin
         gaps_on = ($urandom_range(3) != 0);
         roll = $urandom_range(99);
         if (roll < 80) count = 7'($urandom_range(12, 2));
         else if (roll < 92) count = 7'd64;
         else count = 7'($urandom_range(127));
         n = (int'(count) < NODES) ? int'(count) : NODES;
         if (n >= 2 && $urandom_range(9) != 0) begin
            src = 6'($urandom_range(n - 1));
            do dst = 6'($urandom_range(n - 1)); while (dst == src);
         end else begin
            src = 6'($urandom_range(63));
            dst = 6'($urandom_range(63));
         end
         set_config(src, dst, count);
         if ($urandom_range(1) != 0)
            send_word(mfap_pkg::CMD_CLEAR, 6'($urandom), 6'($urandom), 16'($urandom));
         for (int rep = 0; rep < 1 + ($urandom_range(3) == 0); rep++) begin
            edges = (n <= 12) ? int'($urandom_range(3 * n + 2, n))
                              : int'($urandom_range(60, 20));
            for (int e = 0; e < edges; e++) begin
               if (n >= 1 && $urandom_range(9) != 0) begin
                  a = 6'($urandom_range(n - 1));
                  b = 6'($urandom_range(n - 1));
               end else begin
                  a = 6'($urandom_range(63));
                  b = 6'($urandom_range(63));
               end
               if ($urandom_range(19) == 0)
                  send_word(mfap_pkg::CMD_NONE, a, b, 16'($urandom));
               send_word(mfap_pkg::CMD_ADD, a, b, random_capacity());
            end
            send_word(mfap_pkg::CMD_SOLVE, 6'($urandom), 6'($urandom), 16'($urandom));
         end
      end
   endtask

   // Result side: random back-pressure, some stretches without any
   int stall_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp.ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (gaps_on && $urandom_range(99) < 25) begin
         rsp.ready  <= 1'b0;
         stall_left <= ($urandom_range(9) == 0) ? $urandom_range(40, 5) : $urandom_range(2);
      end else begin
         rsp.ready  <= 1'b1;
      end
   end

   // Each result word is checked against the oldest predicted total
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (flow_expected.size() == 0) begin
            $error("total_flow: unexpected result word, actual %0d", rsp.total_flow);
            fail_count++;
         end else if (rsp.total_flow !== flow_expected[0]) begin
            $error("total_flow: expected %0d, actual %0d", flow_expected[0], rsp.total_flow);
            fail_count++;
            void'(flow_expected.pop_front());
         end else begin
            void'(flow_expected.pop_front());
         end
      end
   end

   // Watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset         <= 1'b1;
      req.valid     <= 1'b0;
      req.command   <= mfap_pkg::CMD_NONE;
      req.from_node <= '0;
      req.to_node   <= '0;
      req.capacity  <= '0;
      csr_we        <= 1'b0;
      csr_index     <= mfap_pkg::CSR_SOURCE;
      csr_wdata     <= '0;
      fail_count    = 0;
      words_sent    = 0;
      gaps_on       = 1'b1;
      clear_pending = 1'b0;
      cfg_source    = 6'd0;
      cfg_sink      = 6'd63;
      cfg_count     = 7'd64;
      foreach (residual[i, j]) residual[i][j] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_basic_commands();
      test_endpoint_cases();
      test_saturation();
      test_random_graphs();

      wait_idle();
      repeat (50) @(posedge clock);
      if (fail_count == 0 && flow_expected.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
